/* src/hckc_pkg.sv */
// hckc_pkg: shared types and constants for the chained-hash key counter
// no dependencies
`timescale 1ns / 1ps
package hckc_pkg;
   localparam int BUCKETS = 256;
   localparam int ENTRIES = 1024;
   localparam int BKT_W = $clog2(BUCKETS);
   localparam int ENT_W = $clog2(ENTRIES);
   localparam int REF_W = $clog2(ENTRIES + 1);
   localparam int HS_W = 9;
   localparam logic [HS_W-1:0] HASH_SIZE_RESET = 9'd211;

   typedef enum logic [1:0] {
      OP_COUNT  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] key;
   } req_word_type;

   typedef struct packed {
      logic        found;
      logic [31:0] count;
      logic        full_res;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MOD, ST_HEAD_RD, ST_HEAD_WAIT, ST_ENT_RD, ST_ENT_WAIT,
      ST_UPDATE, ST_CLEAR, ST_DONE
   } state_type;
endpackage

/* src/hckc_mod.sv */
// hckc_mod: restoring modulo unit, one quotient bit per cycle
// depends on hckc_pkg
`timescale 1ns / 1ps
module hckc_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [hckc_pkg::HS_W-1:0]  divisor,
   output logic                       done,
   output logic [hckc_pkg::BKT_W-1:0] remainder
);
   import hckc_pkg::*;
   logic [31:0]     dvd_ff, dvd_in;
   logic [HS_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic            run_ff, run_in, done_ff, done_in;
   logic [HS_W:0]   trial;

   always_comb begin
      dvd_in = dvd_ff; rem_in = rem_ff; div_in = div_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff, dvd_ff[31]};
      if (start) begin
         dvd_in = dividend; rem_in = '0; cnt_in = 6'd32; run_in = 1'b1;
         div_in = (divisor == '0) ? HS_W'(1) :
                  ((divisor > HS_W'(BUCKETS)) ? HS_W'(BUCKETS) : divisor);
      end else if (run_ff) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = HS_W'(trial - {1'b0, div_ff});
         else rem_in = trial[HS_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in; rem_ff <= rem_in; div_ff <= div_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign remainder = rem_ff[BKT_W-1:0];
endmodule

/* src/hckc_table.sv */
// hckc_table: bucket head memory and entry pool memory with per-head valid bits
// depends on hckc_pkg
`timescale 1ns / 1ps
module hckc_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic [hckc_pkg::BKT_W-1:0] head_addr,
   input  logic                       head_we,
   input  logic [hckc_pkg::REF_W-1:0] head_wdata,
   output logic [hckc_pkg::REF_W-1:0] head_rdata,
   input  logic [hckc_pkg::ENT_W-1:0] ent_addr,
   input  logic                       ent_we,
   input  logic [32+32+hckc_pkg::REF_W-1:0] ent_wdata,
   output logic [32+32+hckc_pkg::REF_W-1:0] ent_rdata
);
   import hckc_pkg::*;
   logic [REF_W-1:0]      head_mem [BUCKETS];
   logic [BUCKETS-1:0]    hvalid_ff;
   logic [REF_W-1:0]      hrd_ff;
   logic                  hv_rd_ff;
   logic [64+REF_W-1:0]   ent_mem [ENTRIES];
   logic [64+REF_W-1:0]   erd_ff;

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_addr] <= head_wdata;
      hrd_ff <= head_mem[head_addr];
      hv_rd_ff <= hvalid_ff[head_addr];
      if (ent_we) ent_mem[ent_addr] <= ent_wdata;
      erd_ff <= ent_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) hvalid_ff <= '0;
      else if (head_we) hvalid_ff[head_addr] <= 1'b1;
   end

   assign head_rdata = hv_rd_ff ? hrd_ff : '0;
   assign ent_rdata = erd_ff;
endmodule

/* src/hash_chained_key_counter.sv */
// hash_chained_key_counter: top level, control sequencer and register port
// depends on hckc_pkg, hckc_mod, hckc_table
// count/lookup: bucket modulo, head read, then the chain walk (an empty bucket counts as one step);
// clear and ignored codes skip both; busy high until strobe ends, no new word before then
// the bucket modulo and the serial chain walk set the rate; receiver cannot stall
// synchronous reset empties all buckets at once (valid bits), no clearing pass
`timescale 1ns / 1ps
module hash_chained_key_counter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hckc_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output hckc_pkg::rsp_word_type rsp_word,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [1:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import hckc_pkg::*;

   // register port: a single register at address zero
   logic [HS_W-1:0] hash_size_ff;
   always_ff @(posedge clock) begin
      if (reset) hash_size_ff <= HASH_SIZE_RESET;
      else if (psel && penable && pwrite && paddr == 2'd0) hash_size_ff <= pwdata[HS_W-1:0];
   end
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {{(32-HS_W){1'b0}}, hash_size_ff} : '0;

   state_type state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      key_ff, key_in;
   logic [BKT_W-1:0] bkt_ff, bkt_in;
   logic [REF_W-1:0] ref_ff, ref_in;     // current chain entry, index+1
   logic [REF_W-1:0] used_ff, used_in;   // entries handed out
   logic [REF_W-1:0] steps_ff, steps_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic             mod_start, mod_done;
   logic [BKT_W-1:0] mod_rem;
   logic             clr, head_we, ent_we;
   logic [REF_W-1:0] head_wdata, head_rdata;
   logic [ENT_W-1:0] ent_addr;
   logic [64+REF_W-1:0] ent_wdata, ent_rdata;
   logic [31:0]      e_key, e_cnt;
   logic [REF_W-1:0] e_link;

   assign {e_key, e_cnt, e_link} = ent_rdata;

   hckc_mod u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(key_ff),
      .divisor(hash_size_ff), .done(mod_done), .remainder(mod_rem)
   );

   hckc_table u_table (
      .clock(clock), .reset(reset), .clear(clr), .head_addr(bkt_ff),
      .head_we(head_we), .head_wdata(head_wdata), .head_rdata(head_rdata),
      .ent_addr(ent_addr), .ent_we(ent_we), .ent_wdata(ent_wdata),
      .ent_rdata(ent_rdata)
   );

   always_comb begin
      state_in = state_ff; op_in = op_ff; key_in = key_ff; bkt_in = bkt_ff;
      ref_in = ref_ff; used_in = used_ff; steps_in = steps_ff;
      rsp_in = rsp_ff; strobe_in = 1'b0;
      mod_start = 1'b0; clr = 1'b0; head_we = 1'b0; ent_we = 1'b0;
      head_wdata = '0;
      ent_addr = ENT_W'(ref_ff - REF_W'(1));
      ent_wdata = {key_ff, e_cnt, e_link};
      unique case (state_ff)
         ST_IDLE: begin
            // no new word while the previous result is still on the strobe
            if (start && !busy) begin
               op_in = req_word.operation; key_in = req_word.key;
               rsp_in = '0; steps_in = '0;
               unique case (op_type'(req_word.operation))
                  OP_COUNT, OP_LOOKUP: state_in = ST_MOD;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MOD: begin
            mod_start = 1'b1; state_in = ST_HEAD_RD;
         end
         ST_HEAD_RD: begin
            // wait for the modulo, then issue the head read
            if (mod_done) begin
               bkt_in = mod_rem; state_in = ST_HEAD_WAIT;
            end
         end
         ST_HEAD_WAIT: state_in = ST_ENT_RD;   // head read in flight
         ST_ENT_RD: begin
            // head data valid, the walk starts at the bucket head
            ref_in = head_rdata;
            state_in = ST_ENT_WAIT;
         end
         ST_ENT_WAIT: begin
            // entry address is ref_ff minus one; read data valid next cycle
            if (ref_ff == '0 || steps_ff == REF_W'(ENTRIES)) begin
               state_in = ST_UPDATE;
               ref_in = '0;
            end else state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (ref_ff != '0 && e_key == key_ff) begin
               rsp_in.found = 1'b1;
               if (op_type'(op_ff) == OP_COUNT) begin
                  ent_we = 1'b1;
                  ent_wdata = {e_key, (e_cnt == '1) ? e_cnt : e_cnt + 32'd1, e_link};
                  rsp_in.count = (e_cnt == '1) ? e_cnt : e_cnt + 32'd1;
               end else rsp_in.count = e_cnt;
               state_in = ST_DONE;
            end else if (ref_ff != '0 && steps_ff + REF_W'(1) < REF_W'(ENTRIES)
                         && e_link != '0) begin
               ref_in = e_link; steps_in = steps_ff + REF_W'(1);
               state_in = ST_ENT_WAIT;
            end else begin
               if (op_type'(op_ff) == OP_COUNT) begin
                  if (used_ff < REF_W'(ENTRIES)) begin
                     ent_we = 1'b1;
                     ent_addr = used_ff[ENT_W-1:0];
                     ent_wdata = {key_ff, 32'd1, head_rdata};
                     head_we = 1'b1;
                     head_wdata = used_ff + REF_W'(1);
                     used_in = used_ff + REF_W'(1);
                     rsp_in.count = 32'd1;
                  end else rsp_in.full_res = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            clr = 1'b1; used_in = '0; state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; bkt_ff <= bkt_in; ref_ff <= ref_in;
      steps_ff <= steps_in; rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE; used_ff <= '0; strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; strobe_ff <= strobe_in;
      end
   end

   assign busy = (state_ff != ST_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_word = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= REF_W'(ENTRIES)) else $error("pool count beyond depth");
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("two strobes in a row");
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.full_res |-> rsp_word.count == '0 && !rsp_word.found)
      else $error("full word carries a count");
endmodule
